@@ rtl/stack_bytecode_execute_unit_core_defines.svh @@
// assertion macros for the stack execute unit checker
`ifndef STACK_BYTECODE_EXECUTE_UNIT_CORE_DEFINES_SVH
`define STACK_BYTECODE_EXECUTE_UNIT_CORE_DEFINES_SVH

// property holds at every edge out of reset
`define SBEU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SBEU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sbeu_pkg.sv @@
`timescale 1ns / 1ps

package sbeu_pkg;

    localparam int WORD_W  = 32;
    localparam int KIND_W  = 3;
    localparam int GIDX_W  = 6;
    localparam int OP_W    = 4;
    localparam int DEPTH_W = 9;
    localparam int ERR_W   = 2;

    localparam logic [KIND_W-1:0] KIND_CONST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STORE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DROP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BINOP = 3'd4;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd5;

    localparam logic [OP_W-1:0] OP_ADD = 4'd1;
    localparam logic [OP_W-1:0] OP_SUB = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV = 4'd4;
    localparam logic [OP_W-1:0] OP_MOD = 4'd5;
    localparam logic [OP_W-1:0] OP_LT  = 4'd6;
    localparam logic [OP_W-1:0] OP_LE  = 4'd7;
    localparam logic [OP_W-1:0] OP_GT  = 4'd8;
    localparam logic [OP_W-1:0] OP_GE  = 4'd9;
    localparam logic [OP_W-1:0] OP_EQ  = 4'd10;
    localparam logic [OP_W-1:0] OP_NE  = 4'd11;
    localparam logic [OP_W-1:0] OP_AND = 4'd12;
    localparam logic [OP_W-1:0] OP_OR  = 4'd13;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZERO   = 2'd3;

    typedef struct packed {
        logic              start;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] value;
    } alu_rsp_t;

endpackage

@@ rtl/sbeu_if.sv @@
`timescale 1ns / 1ps

interface sbeu_in_if;
    import sbeu_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] immediate;
    logic [GIDX_W-1:0] global_index;
    logic [OP_W-1:0]   operator_code;

    modport source (
        output valid,
        output kind,
        output immediate,
        output global_index,
        output operator_code,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  immediate,
        input  global_index,
        input  operator_code,
        output ready
    );
endinterface

interface sbeu_out_if;
    import sbeu_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  top_value;
    logic [DEPTH_W-1:0] stack_depth;
    logic               write_valid;
    logic [WORD_W-1:0]  write_value;
    logic [ERR_W-1:0]   error_code;

    modport source (
        output valid,
        output top_value,
        output stack_depth,
        output write_valid,
        output write_value,
        output error_code,
        input  ready
    );

    modport sink (
        input  valid,
        input  top_value,
        input  stack_depth,
        input  write_valid,
        input  write_value,
        input  error_code,
        output ready
    );
endinterface

@@ rtl/sbeu_alu.sv @@
`timescale 1ns / 1ps

module sbeu_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  sbeu_pkg::alu_req_t req,
    output sbeu_pkg::alu_rsp_t rsp
);
    import sbeu_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_DIV  = 3'b010,
        A_FIX  = 3'b100
    } alu_state_t;

    function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] a);
        return a[WORD_W-1] ? (WORD_W'(0) - a) : a;
    endfunction

    alu_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic              mod_reg, mod_next;

    logic [WORD_W-1:0] fast_res;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W+1:0] diff;
    logic              fits;

    // single-pass operators
    always_comb
    begin
        case (req.op)
            OP_ADD:  fast_res = req.x + req.y;
            OP_SUB:  fast_res = req.x - req.y;
            OP_MUL:  fast_res = req.x * req.y;
            OP_LT:   fast_res = WORD_W'($signed(req.x) < $signed(req.y));
            OP_LE:   fast_res = WORD_W'($signed(req.x) <= $signed(req.y));
            OP_GT:   fast_res = WORD_W'($signed(req.x) > $signed(req.y));
            OP_GE:   fast_res = WORD_W'($signed(req.x) >= $signed(req.y));
            OP_EQ:   fast_res = WORD_W'(req.x == req.y);
            OP_NE:   fast_res = WORD_W'(req.x != req.y);
            OP_AND:  fast_res = WORD_W'((req.x != '0) && (req.y != '0));
            OP_OR:   fast_res = WORD_W'((req.x != '0) || (req.y != '0));
            default: fast_res = '0;
        endcase
    end

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WORD_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
        fits      = !diff[WORD_W+1];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        mod_next   = mod_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op inside {OP_DIV, OP_MOD})
                    begin
                        quo_next   = mag(req.x);
                        dvs_next   = mag(req.y);
                        rem_next   = '0;
                        cnt_next   = '0;
                        neg_q_next = req.x[WORD_W-1] ^ req.y[WORD_W-1];
                        neg_r_next = req.x[WORD_W-1];
                        mod_next   = (req.op == OP_MOD);
                        state_next = A_DIV;
                    end
                    else
                    begin
                        res_next  = fast_res;
                        done_next = 1'b1;
                    end
                end
            end
            A_DIV:
            begin
                rem_next = fits ? diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], fits};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                if (mod_reg)
                begin
                    res_next = neg_r_reg ? (WORD_W'(0) - rem_reg) : rem_reg;
                end
                else
                begin
                    res_next = neg_q_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        mod_reg   <= mod_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

@@ rtl/sbeu_globals.sv @@
`timescale 1ns / 1ps

module sbeu_globals #(
    parameter int GLOBAL_COUNT = 64,
    parameter int GAW          = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [GAW-1:0]              waddr,
    input  logic [sbeu_pkg::WORD_W-1:0] wdata,
    input  logic [GAW-1:0]              raddr,
    output logic [sbeu_pkg::WORD_W-1:0] rdata,
    output logic                        busy
);
    import sbeu_pkg::*;

    logic [WORD_W-1:0] mem [GLOBAL_COUNT];
    logic [WORD_W-1:0] rdata_reg;
    logic [GAW-1:0]    clr_addr_reg;
    logic              clr_busy_reg;

    // zeroing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == GAW'(GLOBAL_COUNT - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + GAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

@@ rtl/stack_bytecode_execute_unit_core.sv @@
`timescale 1ns / 1ps

// channel  modport  payload
// instr    sink     kind, immediate, global_index, operator_code
// result   source   top_value, stack_depth, write_valid, write_value, error_code
//
// one instruction at a time: push, load, store, drop, write and ignored codes pass
// through exec and done before the next transfer; add, sub, mul, compare and logic
// without error also pass the alu state, where div and mod run the shared divider
// taking one bit per cycle; after reset the globals are zeroed with instr.ready low
// a result held by a stalled result channel keeps the next one from finishing

module stack_bytecode_execute_unit_core #(
    parameter int STACK_DEPTH  = 256,
    parameter int GLOBAL_COUNT = 64
) (
    input logic       clk,
    input logic       rst_n,
    sbeu_in_if.sink   instr,
    sbeu_out_if.source result
);
    import sbeu_pkg::*;

    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    localparam int SAW       = $clog2(STACK_DEPTH);
    localparam int GAW       = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
    localparam int GIDX_SPAN = 1 << GIDX_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_ALU   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    logic [WORD_W-1:0]  top_reg, top_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [WORD_W-1:0]  imm_reg;
    logic [GAW-1:0]     gidx_reg;
    logic [OP_W-1:0]    op_reg;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic               wvalid_reg, wvalid_next;
    logic [WORD_W-1:0]  wvalue_reg, wvalue_next;

    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_top_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    logic               out_wvalid_reg;
    logic [WORD_W-1:0]  out_wvalue_reg;
    logic [ERR_W-1:0]   out_err_reg;
    logic               out_load;

    logic [WORD_W-1:0]  stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0]  stk_rdata_reg;
    logic [SAW-1:0]     stk_raddr;
    logic               stk_we;
    logic [SAW-1:0]     stk_waddr;
    logic [WORD_W-1:0]  stk_wdata;

    logic [GAW-1:0]     gidx_map [GIDX_SPAN];
    logic [GAW-1:0]     gidx_in;
    logic               glb_we;
    logic [WORD_W-1:0]  glb_rdata;
    logic               glb_busy;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    logic               in_xfer;
    logic               sp_full;
    logic               sp_empty;
    logic               sp_lt2;

    for (genvar gi = 0; gi < GIDX_SPAN; gi++)
    begin : g_gidx
        assign gidx_map[gi] = GAW'(gi % GLOBAL_COUNT);
    end

    assign gidx_in  = gidx_map[instr.global_index];
    assign in_xfer  = instr.valid && instr.ready;
    assign sp_full  = (sp_reg == SPW'(STACK_DEPTH));
    assign sp_empty = (sp_reg == '0);
    assign sp_lt2   = (sp_reg < SPW'(2));

    // second entry from the top, read while idle
    assign stk_raddr = SAW'(sp_reg - SPW'(2));

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stack_mem[stk_raddr];
    end

    sbeu_globals #(
        .GLOBAL_COUNT (GLOBAL_COUNT),
        .GAW          (GAW)
    ) u_globals (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (glb_we),
        .waddr (gidx_reg),
        .wdata (top_reg),
        .raddr (gidx_in),
        .rdata (glb_rdata),
        .busy  (glb_busy)
    );

    sbeu_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        err_next      = err_reg;
        wvalid_next   = wvalid_reg;
        wvalue_next   = wvalue_reg;
        stk_we        = 1'b0;
        stk_waddr     = SAW'(sp_reg);
        stk_wdata     = imm_reg;
        glb_we        = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;
        alu_req.x     = stk_rdata_reg;
        alu_req.y     = top_reg;
        out_load      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (!glb_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                err_next    = ERR_NONE;
                wvalid_next = 1'b0;
                wvalue_next = '0;
                state_next  = S_DONE;
                case (kind_reg)
                    KIND_CONST, KIND_LOAD:
                    begin
                        if (sp_full)
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                        else
                        begin
                            stk_we    = 1'b1;
                            stk_wdata = (kind_reg == KIND_CONST) ? imm_reg : glb_rdata;
                            top_next  = stk_wdata;
                            sp_next   = sp_reg + SPW'(1);
                        end
                    end
                    KIND_STORE:
                    begin
                        if (sp_empty)
                        begin
                            err_next = ERR_UNDERFLOW;
                        end
                        else
                        begin
                            glb_we = 1'b1;
                        end
                    end
                    KIND_DROP, KIND_WRITE:
                    begin
                        if (sp_empty)
                        begin
                            err_next = ERR_UNDERFLOW;
                        end
                        else
                        begin
                            sp_next  = sp_reg - SPW'(1);
                            top_next = stk_rdata_reg;
                            if (kind_reg == KIND_WRITE)
                            begin
                                wvalid_next = 1'b1;
                                wvalue_next = top_reg;
                            end
                        end
                    end
                    KIND_BINOP:
                    begin
                        if (op_reg inside {[OP_ADD:OP_OR]})
                        begin
                            if (sp_lt2)
                            begin
                                err_next = ERR_UNDERFLOW;
                            end
                            else if ((op_reg inside {OP_DIV, OP_MOD}) && (top_reg == '0))
                            begin
                                err_next = ERR_DIVZERO;
                            end
                            else
                            begin
                                alu_req.start = 1'b1;
                                state_next    = S_ALU;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = SAW'(sp_reg - SPW'(2));
                    stk_wdata  = alu_rsp.value;
                    top_next   = alu_rsp.value;
                    sp_next    = sp_reg - SPW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        err_reg    <= err_next;
        wvalid_reg <= wvalid_next;
        wvalue_reg <= wvalue_next;
        if (in_xfer)
        begin
            kind_reg <= instr.kind;
            imm_reg  <= instr.immediate;
            gidx_reg <= gidx_in;
            op_reg   <= instr.operator_code;
        end
        if (out_load)
        begin
            out_top_reg    <= sp_empty ? '0 : top_reg;
            out_depth_reg  <= DEPTH_W'(sp_reg);
            out_wvalid_reg <= wvalid_reg;
            out_wvalue_reg <= wvalue_reg;
            out_err_reg    <= err_reg;
        end
    end

    assign instr.ready        = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.top_value   = out_top_reg;
    assign result.stack_depth = out_depth_reg;
    assign result.write_valid = out_wvalid_reg;
    assign result.write_value = out_wvalue_reg;
    assign result.error_code  = out_err_reg;

endmodule

@@ rtl/sbeu_checker.sv @@
`timescale 1ns / 1ps
`include "stack_bytecode_execute_unit_core_defines.svh"

module sbeu_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [sbeu_pkg::WORD_W-1:0]  top_value,
    input logic [sbeu_pkg::DEPTH_W-1:0] stack_depth,
    input logic                         write_valid,
    input logic [sbeu_pkg::WORD_W-1:0]  write_value,
    input logic [sbeu_pkg::ERR_W-1:0]   error_code
);
    import sbeu_pkg::*;

    `SBEU_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "ready after transfer")

    `SBEU_ASSERT_ALWAYS(a_write_no_error, (out_valid && write_valid) |-> (error_code == ERR_NONE), "write with error")

    `SBEU_ASSERT_ALWAYS(a_write_value_zero, (out_valid && !write_valid) |-> (write_value == '0), "stray write value")

    `SBEU_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(top_value) && $stable(stack_depth) && $stable(error_code), "stalled result changed")

endmodule

bind stack_bytecode_execute_unit_core sbeu_checker u_sbeu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (instr.valid),
    .in_ready    (instr.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .top_value   (result.top_value),
    .stack_depth (result.stack_depth),
    .write_valid (result.write_valid),
    .write_value (result.write_value),
    .error_code  (result.error_code)
);

@@ bench/stack_bytecode_execute_unit_core_tb.sv @@
`timescale 1ns / 1ps

module stack_bytecode_execute_unit_core_tb;
    import sbeu_pkg::*;

    localparam int STACK_DEPTH    = 256;
    localparam int GLOBAL_COUNT   = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [KIND_W-1:0] KIND_UNDEF6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNDEF7 = 3'd7;
    localparam logic [OP_W-1:0]   OP_UNDEF0   = 4'd0;
    localparam logic [OP_W-1:0]   OP_UNDEF14  = 4'd14;
    localparam logic [OP_W-1:0]   OP_UNDEF15  = 4'd15;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] immediate;
        logic [GIDX_W-1:0] global_index;
        logic [OP_W-1:0]   operator_code;
    } instr_t;

    typedef struct packed {
        logic [WORD_W-1:0]  top_value;
        logic [DEPTH_W-1:0] stack_depth;
        logic               write_valid;
        logic [WORD_W-1:0]  write_value;
        logic [ERR_W-1:0]   error_code;
    } outcome_t;

    typedef struct packed {
        logic     typed;
        instr_t   it;
        outcome_t out;
    } row_t;

    logic clk;
    logic rst_n;

    sbeu_in_if  instr_ch();
    sbeu_out_if result_ch();

    stack_bytecode_execute_unit_core #(
        .STACK_DEPTH  (STACK_DEPTH),
        .GLOBAL_COUNT (GLOBAL_COUNT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    logic [WORD_W-1:0] model_stack [STACK_DEPTH];
    logic [WORD_W-1:0] model_globals [GLOBAL_COUNT];
    int unsigned       model_sp;

    outcome_t    expected_outcomes[$];
    row_t        directed_rows[$];
    int unsigned error_count;
    int unsigned random_count;
    bit          sender_burst;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] magnitude(logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? -v : v;
    endfunction

    function automatic outcome_t execute_instr(instr_t it);
        outcome_t          res;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] q;
        res = '0;
        res.error_code = ERR_NONE;
        case (it.kind)
            KIND_CONST, KIND_LOAD:
            begin
                if (model_sp >= STACK_DEPTH)
                    res.error_code = ERR_OVERFLOW;
                else
                begin
                    model_stack[model_sp] = (it.kind == KIND_CONST) ? it.immediate
                        : model_globals[it.global_index % GLOBAL_COUNT];
                    model_sp++;
                end
            end
            KIND_STORE:
            begin
                if (model_sp == 0)
                    res.error_code = ERR_UNDERFLOW;
                else
                    model_globals[it.global_index % GLOBAL_COUNT] = model_stack[model_sp - 1];
            end
            KIND_DROP:
            begin
                if (model_sp == 0)
                    res.error_code = ERR_UNDERFLOW;
                else
                    model_sp--;
            end
            KIND_BINOP:
            begin
                if (it.operator_code != OP_UNDEF0 && it.operator_code <= OP_OR)
                begin
                    if (model_sp < 2)
                        res.error_code = ERR_UNDERFLOW;
                    else
                    begin
                        y = model_stack[model_sp - 1];
                        x = model_stack[model_sp - 2];
                        if ((it.operator_code == OP_DIV || it.operator_code == OP_MOD) && y == '0)
                            res.error_code = ERR_DIVZERO;
                        else
                        begin
                            case (it.operator_code)
                                OP_ADD: r = x + y;
                                OP_SUB: r = x - y;
                                OP_MUL: r = x * y;
                                OP_DIV:
                                begin
                                    q = magnitude(x) / magnitude(y);
                                    r = (x[WORD_W-1] ^ y[WORD_W-1]) ? -q : q;
                                end
                                OP_MOD:
                                begin
                                    q = magnitude(x) % magnitude(y);
                                    r = x[WORD_W-1] ? -q : q;
                                end
                                OP_LT:  r = ($signed(x) < $signed(y)) ? 32'd1 : 32'd0;
                                OP_LE:  r = ($signed(x) <= $signed(y)) ? 32'd1 : 32'd0;
                                OP_GT:  r = ($signed(x) > $signed(y)) ? 32'd1 : 32'd0;
                                OP_GE:  r = ($signed(x) >= $signed(y)) ? 32'd1 : 32'd0;
                                OP_EQ:  r = (x == y) ? 32'd1 : 32'd0;
                                OP_NE:  r = (x != y) ? 32'd1 : 32'd0;
                                OP_AND: r = (x != '0 && y != '0) ? 32'd1 : 32'd0;
                                default: r = (x != '0 || y != '0) ? 32'd1 : 32'd0;
                            endcase
                            model_stack[model_sp - 2] = r;
                            model_sp--;
                        end
                    end
                end
            end
            KIND_WRITE:
            begin
                if (model_sp == 0)
                    res.error_code = ERR_UNDERFLOW;
                else
                begin
                    res.write_valid = 1'b1;
                    res.write_value = model_stack[model_sp - 1];
                    model_sp--;
                end
            end
            default:
            begin
            end
        endcase
        res.top_value   = (model_sp > 0) ? model_stack[model_sp - 1] : '0;
        res.stack_depth = DEPTH_W'(model_sp);
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return $urandom_range(0, 8) - 32'd4;
        if (sel < 40)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hffff_ffff;
                3: return 32'h8000_0000;
                default: return 32'h7fff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_row(input logic typed, input logic [KIND_W-1:0] kind,
                           input logic [WORD_W-1:0] imm, input logic [GIDX_W-1:0] gidx,
                           input logic [OP_W-1:0] op, input logic [WORD_W-1:0] top,
                           input logic [DEPTH_W-1:0] depth, input logic wv,
                           input logic [WORD_W-1:0] wval, input logic [ERR_W-1:0] err);
        row_t row;
        row.typed                = typed;
        row.it.kind              = kind;
        row.it.immediate         = imm;
        row.it.global_index      = gidx;
        row.it.operator_code     = op;
        row.out.top_value        = top;
        row.out.stack_depth      = depth;
        row.out.write_valid      = wv;
        row.out.write_value      = wval;
        row.out.error_code       = err;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_instr(input instr_t it, input logic typed, input outcome_t fixed);
        outcome_t predicted;
        int       gap;
        instr_ch.valid         <= 1'b1;
        instr_ch.kind          <= it.kind;
        instr_ch.immediate     <= it.immediate;
        instr_ch.global_index  <= it.global_index;
        instr_ch.operator_code <= it.operator_code;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
        predicted = execute_instr(it);
        expected_outcomes.insert(expected_outcomes.size(), typed ? fixed : predicted);
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] op);
        instr_t it;
        it.kind          = kind;
        it.immediate     = pick_value();
        it.global_index  = GIDX_W'($urandom_range(0, GLOBAL_COUNT - 1));
        it.operator_code = (kind == KIND_BINOP) ? op : OP_W'($urandom);
        send_instr(it, 1'b0, '0);
        if (kind <= KIND_WRITE && !(kind == KIND_BINOP && (op == OP_UNDEF0 || op > OP_OR)))
            random_count++;
    endtask

    task automatic drain_results();
        instr_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_outcomes.size() != 0);
    endtask

    function automatic void check_outcome();
        outcome_t got;
        outcome_t want;
        got.top_value   = result_ch.top_value;
        got.stack_depth = result_ch.stack_depth;
        got.write_valid = result_ch.write_valid;
        got.write_value = result_ch.write_value;
        got.error_code  = result_ch.error_code;
        if (expected_outcomes.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("unexpected result: top=%h depth=%0d wv=%b wval=%h err=%0d",
                         got.top_value, got.stack_depth, got.write_valid,
                         got.write_value, got.error_code);
            return;
        end
        want = expected_outcomes.pop_front();
        if (got.top_value !== want.top_value || got.stack_depth !== want.stack_depth ||
            got.write_valid !== want.write_valid || got.write_value !== want.write_value ||
            got.error_code !== want.error_code)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
            begin
                $display("mismatch: expected top=%h depth=%0d wv=%b wval=%h err=%0d",
                         want.top_value, want.stack_depth, want.write_valid,
                         want.write_value, want.error_code);
                $display("          actual   top=%h depth=%0d wv=%b wval=%h err=%0d",
                         got.top_value, got.stack_depth, got.write_valid,
                         got.write_value, got.error_code);
            end
        end
    endfunction

    // result side: random back-pressure with calm stretches
    initial
    begin
        int stall_left;
        int calm_left;
        int stall;
        bit calm;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                check_outcome();
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end
            else
                calm_left--;
            stall = (!calm && stall_left == 0 && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = stall - 1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [KIND_W-1:0] kind;
        logic [OP_W-1:0]   op;
        int unsigned       sel;
        int                len;
        error_count  = 0;
        random_count = 0;
        sender_burst = 1'b0;
        model_sp     = 0;
        foreach (model_stack[i])
            model_stack[i] = '0;
        foreach (model_globals[i])
            model_globals[i] = '0;

        rst_n                  <= 1'b0;
        instr_ch.valid         <= 1'b0;
        instr_ch.kind          <= KIND_CONST;
        instr_ch.immediate     <= '0;
        instr_ch.global_index  <= '0;
        instr_ch.operator_code <= OP_UNDEF0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack, ignored codes, division corner cases, global round trip
        add_row(1, KIND_DROP,   0, 0,  OP_UNDEF0, 0, 0, 0, 0, ERR_UNDERFLOW);
        add_row(1, KIND_WRITE,  0, 0,  OP_UNDEF0, 0, 0, 0, 0, ERR_UNDERFLOW);
        add_row(1, KIND_STORE,  0, 0,  OP_UNDEF0, 0, 0, 0, 0, ERR_UNDERFLOW);
        add_row(1, KIND_BINOP,  0, 0,  OP_ADD,    0, 0, 0, 0, ERR_UNDERFLOW);
        add_row(1, KIND_BINOP,  0, 0,  OP_UNDEF0, 0, 0, 0, 0, ERR_NONE);
        add_row(1, KIND_UNDEF6, 0, 0,  OP_UNDEF0, 0, 0, 0, 0, ERR_NONE);
        add_row(1, KIND_UNDEF7, 0, 0,  OP_UNDEF0, 0, 0, 0, 0, ERR_NONE);
        add_row(1, KIND_CONST,  32'h8000_0000, 0, OP_UNDEF0, 32'h8000_0000, 1, 0, 0, ERR_NONE);
        add_row(1, KIND_BINOP,  0, 0, OP_ADD, 32'h8000_0000, 1, 0, 0, ERR_UNDERFLOW);
        add_row(1, KIND_CONST,  32'hffff_ffff, 0, OP_UNDEF0, 32'hffff_ffff, 2, 0, 0, ERR_NONE);
        add_row(1, KIND_BINOP,  0, 0, OP_DIV, 32'h8000_0000, 1, 0, 0, ERR_NONE);
        add_row(1, KIND_CONST,  32'hffff_ffff, 0, OP_UNDEF0, 32'hffff_ffff, 2, 0, 0, ERR_NONE);
        add_row(1, KIND_BINOP,  0, 0, OP_MOD, 0, 1, 0, 0, ERR_NONE);
        add_row(1, KIND_CONST,  0, 0, OP_UNDEF0, 0, 2, 0, 0, ERR_NONE);
        add_row(1, KIND_BINOP,  0, 0, OP_DIV, 0, 2, 0, 0, ERR_DIVZERO);
        add_row(1, KIND_BINOP,  0, 0, OP_MOD, 0, 2, 0, 0, ERR_DIVZERO);
        add_row(1, KIND_BINOP,  0, 0, OP_UNDEF15, 0, 2, 0, 0, ERR_NONE);
        add_row(1, KIND_BINOP,  0, 0, OP_UNDEF14, 0, 2, 0, 0, ERR_NONE);
        add_row(1, KIND_CONST,  32'h7fff_ffff, 0, OP_UNDEF0, 32'h7fff_ffff, 3, 0, 0, ERR_NONE);
        add_row(1, KIND_STORE,  0, 63, OP_UNDEF0, 32'h7fff_ffff, 3, 0, 0, ERR_NONE);
        add_row(1, KIND_LOAD,   0, 63, OP_UNDEF0, 32'h7fff_ffff, 4, 0, 0, ERR_NONE);
        add_row(1, KIND_WRITE,  0, 0, OP_UNDEF0, 32'h7fff_ffff, 3, 1, 32'h7fff_ffff, ERR_NONE);
        add_row(0, KIND_CONST,  32'h7fff_ffff, 0, OP_UNDEF0, 0, 0, 0, 0, ERR_NONE);
        add_row(0, KIND_BINOP,  0, 0, OP_ADD, 0, 0, 0, 0, ERR_NONE);
        add_row(0, KIND_CONST,  32'hdead_beef, 0, OP_UNDEF0, 0, 0, 0, 0, ERR_NONE);
        add_row(0, KIND_BINOP,  0, 0, OP_MUL, 0, 0, 0, 0, ERR_NONE);
        add_row(0, KIND_BINOP,  0, 0, OP_SUB, 0, 0, 0, 0, ERR_NONE);

        foreach (directed_rows[i])
            send_instr(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].out);
        drain_results();

        // fill up, push past the top, then fold down with binops, drops and writes
        while (model_sp < STACK_DEPTH)
            send_random(($urandom_range(0, 3) == 0) ? KIND_LOAD : KIND_CONST, OP_UNDEF0);
        repeat (3) send_random(($urandom_range(0, 1) == 0) ? KIND_LOAD : KIND_CONST, OP_UNDEF0);
        while (model_sp > 0)
        begin
            sel = $urandom_range(0, 99);
            if (model_sp >= 2 && sel < 75)
                send_random(KIND_BINOP, OP_W'($urandom_range(OP_ADD, OP_OR)));
            else if (sel < 85)
                send_random(KIND_STORE, OP_UNDEF0);
            else
                send_random(($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_DROP, OP_UNDEF0);
        end
        send_random(KIND_WRITE, OP_UNDEF0);
        send_random(KIND_BINOP, OP_W'($urandom_range(OP_ADD, OP_OR)));

        while (random_count < RANDOM_ITEMS)
        begin
            len          = $urandom_range(10, 60);
            sender_burst = ($urandom_range(0, 4) == 0);
            repeat (len)
            begin
                sel = $urandom_range(0, 99);
                op  = OP_W'($urandom_range(OP_ADD, OP_OR));
                if (sel < 5)
                begin
                    case ($urandom_range(0, 4))
                        0: kind = KIND_UNDEF6;
                        1: kind = KIND_UNDEF7;
                        default:
                        begin
                            kind = KIND_BINOP;
                            case ($urandom_range(0, 2))
                                0: op = OP_UNDEF0;
                                1: op = OP_UNDEF14;
                                default: op = OP_UNDEF15;
                            endcase
                        end
                    endcase
                end
                else
                begin
                    if (sel < 30)
                        kind = KIND_CONST;
                    else if (sel < 40)
                        kind = KIND_LOAD;
                    else if (sel < 48)
                        kind = KIND_STORE;
                    else if (sel < 55)
                        kind = KIND_DROP;
                    else if (sel < 88)
                        kind = KIND_BINOP;
                    else
                        kind = KIND_WRITE;
                    if (((kind == KIND_BINOP && model_sp < 2) ||
                         (kind != KIND_CONST && kind != KIND_LOAD && model_sp == 0)) &&
                        $urandom_range(0, 9) != 0)
                        kind = KIND_CONST;
                    if ((kind == KIND_CONST || kind == KIND_LOAD) && model_sp > 48 &&
                        $urandom_range(0, 9) < 6)
                        kind = KIND_WRITE;
                end
                send_random(kind, op);
            end
            if ($urandom_range(0, 5) == 0)
                drain_results();
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
